FILE: rtl/bcpa_pkg.sv
// Shared constants, codes and types of the contiguous page allocator.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package bcpa_pkg;

  // Page frames held in the bitmap, and the page size as a shift.
  localparam int MAX_PAGES  = 4096;
  localparam int PAGE_SHIFT = 12;

  // Fixed field widths.
  localparam int ADDR_W = 64;
  localparam int LEN_W  = 13;
  localparam int END_W  = LEN_W + 1;

  // Bitmap organisation: one memory word holds WORD_BITS used-bits.
  localparam int WORD_BITS  = 64;
  localparam int IDX_W      = $clog2(MAX_PAGES);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WORD_IDX_W = IDX_W - BIT_W;
  localparam int MAP_WORDS  = MAX_PAGES / WORD_BITS;

  // Bit counter of the serial adder.
  localparam int CNT_W = $clog2(ADDR_W);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE   = 1'b1;

  // Request commands.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_LD,
    ST_SCAN_BIT,
    ST_ADD,
    ST_RANGE,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic cin;
  } add_ctrl_t;

  typedef struct packed {
    logic                  en;
    logic [WORD_IDX_W-1:0] addr;
    logic [WORD_BITS-1:0]  data;
  } bm_wr_t;

endpackage

FILE: rtl/bcpa_serial_add.sv
// Bit-serial 64-bit adder: operands shift out one bit a cycle while step is set, the sum shifts in.
// Depends on bcpa_pkg for widths and the control struct.
`timescale 1ns / 1ps

module bcpa_serial_add (
  input  logic                       clk,
  input  bcpa_pkg::add_ctrl_t        ctrl,
  input  logic [bcpa_pkg::ADDR_W-1:0] opa_in,
  input  logic [bcpa_pkg::ADDR_W-1:0] opb_in,
  output logic [bcpa_pkg::ADDR_W-1:0] sum
);

  logic [bcpa_pkg::ADDR_W-1:0] opa;
  logic [bcpa_pkg::ADDR_W-1:0] opb;
  logic                        carry;
  logic                        sum_bit;

  assign sum_bit = opa[0] ^ opb[0] ^ carry;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      opa   <= opa_in;
      opb   <= opb_in;
      carry <= ctrl.cin;
    end else if (ctrl.step) begin
      opa   <= opa >> 1;
      opb   <= opb >> 1;
      carry <= (opa[0] & opb[0]) | (carry & (opa[0] ^ opb[0]));
      sum   <= {sum_bit, sum[bcpa_pkg::ADDR_W-1:1]};
    end
  end

endmodule

FILE: rtl/bcpa_bitmap.sv
// Used-bit store: a word-wide memory with a registered read port and per-word
// valid bits, so that a word never written since reset reads as all free.
// Depends on bcpa_pkg for widths and the write struct.
`timescale 1ns / 1ps

module bcpa_bitmap (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [bcpa_pkg::WORD_IDX_W-1:0] rd_addr,
  output logic [bcpa_pkg::WORD_BITS-1:0]  rd_word,
  input  bcpa_pkg::bm_wr_t                wr
);

  logic [bcpa_pkg::WORD_BITS-1:0] mem [bcpa_pkg::MAP_WORDS];
  logic [bcpa_pkg::MAP_WORDS-1:0] word_valid;
  logic [bcpa_pkg::WORD_BITS-1:0] mem_q;
  logic                           rd_vld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
      rd_vld     <= 1'b0;
    end else begin
      if (wr.en) begin
        word_valid[wr.addr] <= 1'b1;
      end
      rd_vld <= word_valid[rd_addr];
    end
  end

  assign rd_word = rd_vld ? mem_q : '0;

endmodule

FILE: rtl/bitmap_contiguous_page_allocator.sv
// Top level of the first-fit contiguous page allocator: control sequencer,
// bit-serial bitmap scan, word-wise run marking and the result register.
// Depends on bcpa_pkg, bcpa_bitmap and bcpa_serial_add.
`timescale 1ns / 1ps

//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------
//  request  | in_valid / in_stall  | cmd, run_length, page_addr
//  result   | out_valid / out_stall| ok, granted_addr, granted_count
//  config   | cfg_we               | cfg_index, cfg_data
//
// An allocate scans pages one a cycle to the end of the first free run, forms
// the granted address in the serial adder and marks each word of the run; a
// free forms the page offset in the serial adder and clears each word of the
// run. Reset is synchronous and frees every page at once through per-word
// valid bits. in_stall is high only while a request is in work; a finished
// result waits in the output register while the next one comes in.

module bitmap_contiguous_page_allocator (
  input  logic                                clk,
  input  logic                                rst,

  input  logic                                cfg_we,
  input  logic [bcpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bcpa_pkg::ADDR_W-1:0]         cfg_data,

  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                cmd,
  input  logic [bcpa_pkg::LEN_W-1:0]          run_length,
  input  logic [bcpa_pkg::ADDR_W-1:0]         page_addr,

  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                ok,
  output logic [bcpa_pkg::ADDR_W-1:0]         granted_addr,
  output logic [bcpa_pkg::LEN_W-1:0]          granted_count
);

  // Configuration registers.
  logic [bcpa_pkg::LEN_W-1:0]  pages_in_use;
  logic [bcpa_pkg::ADDR_W-1:0] frame_base;

  // Sequencer state and the registers of the request in work.
  bcpa_pkg::state_t state;
  bcpa_pkg::state_t state_next;

  logic                              is_free;
  logic                              r_ok;
  logic [bcpa_pkg::LEN_W-1:0]        len;
  logic [bcpa_pkg::IDX_W-1:0]        p;
  logic [bcpa_pkg::LEN_W-1:0]        run;
  logic [bcpa_pkg::WORD_BITS-1:0]    shreg;
  logic [bcpa_pkg::CNT_W-1:0]        cnt;
  logic [bcpa_pkg::IDX_W-1:0]        lo;
  logic [bcpa_pkg::IDX_W-1:0]        last;
  logic [bcpa_pkg::WORD_IDX_W-1:0]   cur_w;

  // Combinational helpers.
  logic                              in_fire;
  logic                              out_free;
  logic [bcpa_pkg::LEN_W-1:0]        lim;
  logic                              alloc_bad;
  logic                              scan_bit;
  logic [bcpa_pkg::LEN_W-1:0]        run_inc;
  logic                              hit;
  logic                              at_end;
  logic [bcpa_pkg::IDX_W-1:0]        start_a;
  logic                              add_done;
  logic                              free_out_of_range;
  logic [bcpa_pkg::IDX_W-1:0]        start_f;
  logic [bcpa_pkg::END_W-1:0]        end_f;
  logic [bcpa_pkg::IDX_W-1:0]        last_f;
  logic [bcpa_pkg::WORD_IDX_W-1:0]   last_w;
  logic [bcpa_pkg::BIT_W-1:0]        lo_b;
  logic [bcpa_pkg::BIT_W-1:0]        hi_b;
  logic [bcpa_pkg::WORD_BITS-1:0]    mask;

  // Connections to the bitmap and the serial adder.
  logic [bcpa_pkg::WORD_IDX_W-1:0]   rd_addr;
  logic [bcpa_pkg::WORD_BITS-1:0]    rd_word;
  bcpa_pkg::bm_wr_t                  bm_wr;
  bcpa_pkg::add_ctrl_t               add_ctrl;
  logic [bcpa_pkg::ADDR_W-1:0]       add_opa;
  logic [bcpa_pkg::ADDR_W-1:0]       add_opb;
  logic [bcpa_pkg::ADDR_W-1:0]       sum;

  bcpa_bitmap u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_word (rd_word),
    .wr      (bm_wr)
  );

  bcpa_serial_add u_add (
    .clk    (clk),
    .ctrl   (add_ctrl),
    .opa_in (add_opa),
    .opb_in (add_opb),
    .sum    (sum)
  );

  assign in_stall = (state != bcpa_pkg::ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // A page count above the bitmap size acts as the bitmap size.
  assign lim = (pages_in_use > bcpa_pkg::LEN_W'(bcpa_pkg::MAX_PAGES)) ?
               bcpa_pkg::LEN_W'(bcpa_pkg::MAX_PAGES) : pages_in_use;

  // A zero-length allocation, or one not below the page count, fails without a scan.
  assign alloc_bad = (run_length == '0) || (run_length >= lim);

  // First-fit scan: run counts the free pages ending at page p.
  assign scan_bit = shreg[0];
  assign run_inc  = run + bcpa_pkg::LEN_W'(1);
  assign hit      = !scan_bit && (run_inc == len);
  assign at_end   = (bcpa_pkg::LEN_W'(p) == lim - bcpa_pkg::LEN_W'(1));
  assign start_a  = bcpa_pkg::IDX_W'(bcpa_pkg::LEN_W'(p) + bcpa_pkg::LEN_W'(1) - len);

  assign add_done = (cnt == '1);

  // Free range: the page index is the difference shifted down by the page size.
  // Indices beyond the bitmap are dropped, and the run is clipped at its end.
  assign free_out_of_range = |sum[bcpa_pkg::ADDR_W-1:bcpa_pkg::PAGE_SHIFT+bcpa_pkg::IDX_W];
  assign start_f = sum[bcpa_pkg::PAGE_SHIFT +: bcpa_pkg::IDX_W];
  assign end_f   = bcpa_pkg::END_W'(start_f) + bcpa_pkg::END_W'(len);
  assign last_f  = (end_f > bcpa_pkg::END_W'(bcpa_pkg::MAX_PAGES)) ?
                   bcpa_pkg::IDX_W'(bcpa_pkg::MAX_PAGES - 1) :
                   bcpa_pkg::IDX_W'(end_f - bcpa_pkg::END_W'(1));

  // Bit mask of the run within the word being marked or cleared.
  assign last_w = last[bcpa_pkg::IDX_W-1:bcpa_pkg::BIT_W];
  assign lo_b   = (cur_w == lo[bcpa_pkg::IDX_W-1:bcpa_pkg::BIT_W]) ?
                  lo[bcpa_pkg::BIT_W-1:0] : '0;
  assign hi_b   = (cur_w == last_w) ? last[bcpa_pkg::BIT_W-1:0] : '1;

  always_comb begin
    for (int i = 0; i < bcpa_pkg::WORD_BITS; i++) begin
      mask[i] = (bcpa_pkg::BIT_W'(i) >= lo_b) && (bcpa_pkg::BIT_W'(i) <= hi_b);
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pages_in_use <= '0;
      frame_base   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bcpa_pkg::CFG_PAGES_IN_USE: pages_in_use <= cfg_data[bcpa_pkg::LEN_W-1:0];
        bcpa_pkg::CFG_FRAME_BASE:   frame_base   <= cfg_data;
        default: ;
      endcase
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bcpa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory port and adder control.
  always_comb begin
    state_next    = state;
    rd_addr       = '0;
    bm_wr.en      = 1'b0;
    bm_wr.addr    = cur_w;
    bm_wr.data    = is_free ? (rd_word & ~mask) : (rd_word | mask);
    add_ctrl.load = 1'b0;
    add_ctrl.step = 1'b0;
    add_ctrl.cin  = 1'b0;
    add_opa       = frame_base;
    add_opb       = bcpa_pkg::ADDR_W'(start_a) << bcpa_pkg::PAGE_SHIFT;

    case (state)
      bcpa_pkg::ST_IDLE: begin
        // Free: page_addr - frame_base as page_addr + ~frame_base + 1.
        add_opa      = page_addr;
        add_opb      = ~frame_base;
        add_ctrl.cin = 1'b1;
        if (in_fire) begin
          if (cmd == bcpa_pkg::CMD_FREE) begin
            if (run_length == '0) begin
              state_next = bcpa_pkg::ST_FINISH;
            end else begin
              add_ctrl.load = 1'b1;
              state_next    = bcpa_pkg::ST_ADD;
            end
          end else if (alloc_bad) begin
            state_next = bcpa_pkg::ST_FINISH;
          end else begin
            state_next = bcpa_pkg::ST_SCAN_LD;
          end
        end
      end
      bcpa_pkg::ST_SCAN_LD: begin
        state_next = bcpa_pkg::ST_SCAN_BIT;
      end
      bcpa_pkg::ST_SCAN_BIT: begin
        // The next word is fetched while the current one shifts out.
        rd_addr = p[bcpa_pkg::IDX_W-1:bcpa_pkg::BIT_W] + bcpa_pkg::WORD_IDX_W'(1);
        if (hit) begin
          // Granted address: frame_base + (start << PAGE_SHIFT).
          add_ctrl.load = 1'b1;
          state_next    = bcpa_pkg::ST_ADD;
        end else if (at_end) begin
          state_next = bcpa_pkg::ST_FINISH;
        end
      end
      bcpa_pkg::ST_ADD: begin
        add_ctrl.step = 1'b1;
        if (add_done) begin
          state_next = is_free ? bcpa_pkg::ST_RANGE : bcpa_pkg::ST_MARK_RD;
        end
      end
      bcpa_pkg::ST_RANGE: begin
        state_next = free_out_of_range ? bcpa_pkg::ST_FINISH : bcpa_pkg::ST_MARK_RD;
      end
      bcpa_pkg::ST_MARK_RD: begin
        rd_addr    = cur_w;
        state_next = bcpa_pkg::ST_MARK_WR;
      end
      bcpa_pkg::ST_MARK_WR: begin
        rd_addr  = cur_w;
        bm_wr.en = 1'b1;
        state_next = (cur_w == last_w) ? bcpa_pkg::ST_FINISH : bcpa_pkg::ST_MARK_RD;
      end
      bcpa_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = bcpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bcpa_pkg::ST_IDLE;
      end
    endcase
  end

  // Working registers of the request in progress.
  always_ff @(posedge clk) begin
    case (state)
      bcpa_pkg::ST_IDLE: begin
        if (in_fire) begin
          is_free <= (cmd == bcpa_pkg::CMD_FREE);
          len     <= run_length;
          r_ok    <= 1'b0;
          cnt     <= '0;
        end
      end
      bcpa_pkg::ST_SCAN_LD: begin
        shreg <= rd_word;
        p     <= '0;
        run   <= '0;
      end
      bcpa_pkg::ST_SCAN_BIT: begin
        run <= scan_bit ? '0 : run_inc;
        if (hit) begin
          r_ok  <= 1'b1;
          lo    <= start_a;
          last  <= p;
          cur_w <= start_a[bcpa_pkg::IDX_W-1:bcpa_pkg::BIT_W];
          cnt   <= '0;
        end else begin
          p     <= p + bcpa_pkg::IDX_W'(1);
          shreg <= (p[bcpa_pkg::BIT_W-1:0] == '1) ? rd_word : (shreg >> 1);
        end
      end
      bcpa_pkg::ST_ADD: begin
        cnt <= cnt + bcpa_pkg::CNT_W'(1);
      end
      bcpa_pkg::ST_RANGE: begin
        r_ok  <= 1'b1;
        lo    <= start_f;
        last  <= last_f;
        cur_w <= start_f[bcpa_pkg::IDX_W-1:bcpa_pkg::BIT_W];
      end
      bcpa_pkg::ST_MARK_WR: begin
        cur_w <= cur_w + bcpa_pkg::WORD_IDX_W'(1);
      end
      default: ;
    endcase
  end

  // Result register: it holds a finished result until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == bcpa_pkg::ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bcpa_pkg::ST_FINISH && out_free) begin
      ok            <= r_ok;
      granted_addr  <= (r_ok && !is_free) ? sum : '0;
      granted_count <= (r_ok && !is_free) ? len : '0;
    end
  end

  // The run being marked or cleared is never empty.
  a_range_order: assert property (@(posedge clk) disable iff (rst)
    state == bcpa_pkg::ST_MARK_WR |-> lo <= last)
    else $error("marking range has its first page after its last");

  // The word sweep stays between the first and the last word of the run.
  a_word_sweep: assert property (@(posedge clk) disable iff (rst)
    state == bcpa_pkg::ST_MARK_WR |->
      cur_w <= last_w && cur_w >= lo[bcpa_pkg::IDX_W-1:bcpa_pkg::BIT_W])
    else $error("word sweep left the range of the run");

  // A new result only ever comes from the finishing step of a request.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == bcpa_pkg::ST_FINISH)
    else $error("result raised outside the finishing step");

endmodule

FILE: tb/bitmap_contiguous_page_allocator_tb.sv
// Self-checking testbench of the first-fit contiguous page allocator: request
// and result traffic with random gaps, checked against a bitmap predictor.
// Depends on bcpa_pkg and bitmap_contiguous_page_allocator.
`timescale 1ns / 1ps

module bitmap_contiguous_page_allocator_tb;

  // The limit must cover a full scan of 4096 pages with the serial add and the
  // marking pass, plus the longest output stall and the longest request gap.
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic                        op;
    logic [bcpa_pkg::LEN_W-1:0]  len;
    logic [bcpa_pkg::ADDR_W-1:0] addr;
  } req_t;

  typedef struct packed {
    logic                        ok;
    logic [bcpa_pkg::ADDR_W-1:0] addr;
    logic [bcpa_pkg::LEN_W-1:0]  count;
  } grant_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [bcpa_pkg::CFG_IDX_W-1:0] cfg_index = bcpa_pkg::CFG_PAGES_IN_USE;
  logic [bcpa_pkg::ADDR_W-1:0]    cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           cmd = bcpa_pkg::CMD_ALLOC;
  logic [bcpa_pkg::LEN_W-1:0]     run_length = '0;
  logic [bcpa_pkg::ADDR_W-1:0]    page_addr = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           ok;
  logic [bcpa_pkg::ADDR_W-1:0]    granted_addr;
  logic [bcpa_pkg::LEN_W-1:0]     granted_count;

  bitmap_contiguous_page_allocator u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .run_length   (run_length),
    .page_addr    (page_addr),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ok           (ok),
    .granted_addr (granted_addr),
    .granted_count(granted_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Our own copy of the allocator: one used-bit per page frame and the two
  // registers as last written. All of it starts as the block does after reset.
  logic [bcpa_pkg::MAX_PAGES-1:0] used_map = '0;
  logic [bcpa_pkg::LEN_W-1:0]     cur_pages = '0;
  logic [bcpa_pkg::ADDR_W-1:0]    cur_base = '0;

  req_t   pending_requests[$];
  grant_t expected_grants[$];

  int     mismatches = 0;
  int     idle_cycles = 0;
  int     send_gap = 0;
  int     hold_left = 0;
  logic   req_taken = 1'b0;
  logic   calm = 1'b0;
  req_t   next_req;
  req_t   seen_req;
  grant_t want;

  // Works out the outcome of one request and applies it to the bitmap copy.
  function automatic grant_t predict_grant(input req_t rq);
    grant_t                      g;
    logic [bcpa_pkg::ADDR_W-1:0] first;
    logic [bcpa_pkg::ADDR_W-1:0] pg;
    logic [bcpa_pkg::ADDR_W-1:0] offs;
    int                          lim;
    int                          run;
    int                          p;
    int                          k;
    int                          hit;
    g = '0;
    // A limit above the size of the bitmap behaves as the bitmap size.
    lim = (int'(cur_pages) > bcpa_pkg::MAX_PAGES) ? bcpa_pkg::MAX_PAGES : int'(cur_pages);
    if (rq.op == bcpa_pkg::CMD_FREE) begin
      if (rq.len != '0) begin
        // The offset within the page is dropped; an address below the frame
        // base wraps round to an index far beyond the bitmap.
        first = (rq.addr - cur_base) >> bcpa_pkg::PAGE_SHIFT;
        for (k = 0; k < int'(rq.len); k++) begin
          pg = first + bcpa_pkg::ADDR_W'(k);
          if (pg < bcpa_pkg::ADDR_W'(bcpa_pkg::MAX_PAGES)) begin
            used_map[pg[bcpa_pkg::IDX_W-1:0]] = 1'b0;
          end
        end
        g.ok = 1'b1;
      end
    end else if (rq.len != '0 && int'(rq.len) < lim) begin
      run = 0;
      hit = -1;
      for (p = 0; p < lim && hit < 0; p++) begin
        if (used_map[bcpa_pkg::IDX_W'(p)]) begin
          run = 0;
        end else begin
          run++;
          if (run == int'(rq.len)) hit = p + 1 - int'(rq.len);
        end
      end
      if (hit >= 0) begin
        for (k = hit; k < hit + int'(rq.len); k++) used_map[bcpa_pkg::IDX_W'(k)] = 1'b1;
        offs = bcpa_pkg::ADDR_W'(hit);
        g.ok = 1'b1;
        g.addr = cur_base + (offs << bcpa_pkg::PAGE_SHIFT);
        g.count = rq.len;
      end
    end
    return g;
  endfunction

  // Half the time no gap, often a short one, now and then a long one; nothing at
  // all while a calm stretch is in force.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = int'($urandom_range(0, 99));
    if (r < 50) return 0;
    if (r < 85) return int'($urandom_range(1, 3));
    if (r < 97) return int'($urandom_range(4, 15));
    return int'($urandom_range(30, 120));
  endfunction

  // Request driver. A presented request is held until it is taken; after
  // that the next one follows once its gap has run out.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      req_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        next_req = pending_requests.pop_front();
        in_valid <= 1'b1;
        cmd <= next_req.op;
        run_length <= next_req.len;
        page_addr <= next_req.addr;
        send_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The result side stalls in bursts of the same shape as the request gaps.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) hold_left = pick_gap();
    end
  end

  // Monitor. Results are checked against the oldest prediction before any
  // request taken at the same edge adds a new one. The watchdog counts edges
  // at which neither channel moves and no register is written.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        if (expected_grants.size() == 0) begin
          mismatches++;
          $display("%0t: result with no request waiting, ok %b addr %h count %0d",
                   $time, ok, granted_addr, granted_count);
        end else begin
          want = expected_grants.pop_front();
          if (ok !== want.ok) begin
            mismatches++;
            $display("%0t: ok mismatch, expected %b, actual %b", $time, want.ok, ok);
          end
          if (granted_addr !== want.addr) begin
            mismatches++;
            $display("%0t: granted_addr mismatch, expected %h, actual %h",
                     $time, want.addr, granted_addr);
          end
          if (granted_count !== want.count) begin
            mismatches++;
            $display("%0t: granted_count mismatch, expected %0d, actual %0d",
                     $time, want.count, granted_count);
          end
        end
      end
      if (in_valid && !in_stall) begin
        idle_cycles = 0;
        req_taken = 1'b1;
        seen_req.op = cmd;
        seen_req.len = run_length;
        seen_req.addr = page_addr;
        expected_grants.push_back(predict_grant(seen_req));
      end
      if (cfg_we) idle_cycles = 0;
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic queue_request(input logic op, input logic [bcpa_pkg::LEN_W-1:0] len,
                               input logic [bcpa_pkg::ADDR_W-1:0] addr);
    req_t rq;
    rq.op = op;
    rq.len = len;
    rq.addr = addr;
    pending_requests.push_back(rq);
  endtask

  // Waits until every queued request has been sent and every result seen.
  // Each request always yields a result, so the wait ends.
  task automatic settle();
    do begin
      @(posedge clk);
      #1;
    end while (pending_requests.size() != 0 || in_valid || expected_grants.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bcpa_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bcpa_pkg::ADDR_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == bcpa_pkg::CFG_PAGES_IN_USE) cur_pages = val[bcpa_pkg::LEN_W-1:0];
    else cur_base = val;
  endtask

  // The page count sits in the low bits; the bits above it carry noise.
  task automatic set_pages(input logic [bcpa_pkg::LEN_W-1:0] n);
    logic [bcpa_pkg::ADDR_W-1:0] val;
    val = {$urandom, $urandom};
    val[bcpa_pkg::LEN_W-1:0] = n;
    write_reg(bcpa_pkg::CFG_PAGES_IN_USE, val);
  endtask

  // One random phase under a fixed setting. Half of the requests are
  // allocations, mostly of modest runs, and a third are frees aimed at pages
  // within the limit, so the bitmap fills, fragments and reopens; the rest is
  // noise over the full field ranges. The sender pauses for every result halfway.
  task automatic rand_phase(input logic [bcpa_pkg::LEN_W-1:0] pages,
                            input logic [bcpa_pkg::ADDR_W-1:0] base,
                            input int count);
    int                          lim;
    int                          n;
    int                          r;
    logic [bcpa_pkg::LEN_W-1:0]  len;
    logic [bcpa_pkg::ADDR_W-1:0] junk;
    logic [bcpa_pkg::ADDR_W-1:0] idx64;
    set_pages(pages);
    write_reg(bcpa_pkg::CFG_FRAME_BASE, base);
    lim = (int'(pages) > bcpa_pkg::MAX_PAGES) ? bcpa_pkg::MAX_PAGES : int'(pages);
    calm = ($urandom_range(0, 3) == 0);
    for (n = 0; n < count; n++) begin
      if (n == count / 2) begin
        settle();
        calm = ($urandom_range(0, 3) == 0);
      end
      r = int'($urandom_range(0, 99));
      junk = {$urandom, $urandom};
      if (r < 50) begin
        if (r < 6 && lim > 0) len = bcpa_pkg::LEN_W'($urandom_range(lim / 2, lim));
        else if (lim > 8) len = bcpa_pkg::LEN_W'($urandom_range(1, lim / 4));
        else len = bcpa_pkg::LEN_W'(1);
        queue_request(bcpa_pkg::CMD_ALLOC, len, junk);
      end else if (r < 85) begin
        idx64 = (lim > 0) ? bcpa_pkg::ADDR_W'($urandom_range(0, lim - 1)) :
                            bcpa_pkg::ADDR_W'($urandom_range(0, 63));
        queue_request(bcpa_pkg::CMD_FREE, bcpa_pkg::LEN_W'($urandom_range(1, 12)),
                      base + (idx64 << bcpa_pkg::PAGE_SHIFT) +
                      bcpa_pkg::ADDR_W'($urandom_range(0, 4095)));
      end else begin
        if (r < 92) begin
          idx64 = bcpa_pkg::ADDR_W'($urandom_range(0, 8191));
          junk = base + (idx64 << bcpa_pkg::PAGE_SHIFT) +
                 bcpa_pkg::ADDR_W'(junk[bcpa_pkg::PAGE_SHIFT-1:0]);
        end
        queue_request(1'($urandom_range(0, 1)), bcpa_pkg::LEN_W'($urandom), junk);
      end
    end
    settle();
    calm = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Straight out of reset no pages are in use, so nothing can be granted.
    queue_request(bcpa_pkg::CMD_ALLOC, 1, '0);
    queue_request(bcpa_pkg::CMD_FREE, 3, '0);
    queue_request(bcpa_pkg::CMD_ALLOC, 0, '1);
    settle();

    // A small window of 64 pages above a plain base.
    set_pages(64);
    write_reg(bcpa_pkg::CFG_FRAME_BASE, 64'h0000_00A0_0000_0000);
    queue_request(bcpa_pkg::CMD_ALLOC, 0, '0);                     // zero length fails
    queue_request(bcpa_pkg::CMD_ALLOC, 64, '0);                    // equal to the limit
    queue_request(bcpa_pkg::CMD_ALLOC, 8191, '1);                  // widest length fails
    queue_request(bcpa_pkg::CMD_ALLOC, 63, '0);                    // pages 0 to 62
    queue_request(bcpa_pkg::CMD_ALLOC, 1, '0);                     // page 63
    queue_request(bcpa_pkg::CMD_ALLOC, 1, '0);                     // no free run left
    queue_request(bcpa_pkg::CMD_FREE, 0, 64'h0000_00A0_0000_0000); // zero-length free
    queue_request(bcpa_pkg::CMD_FREE, 2, 64'h0000_00A0_0000_AFFF); // pages 10, 11
    queue_request(bcpa_pkg::CMD_ALLOC, 2, '0);                     // refills pages 10, 11
    queue_request(bcpa_pkg::CMD_FREE, 5, 64'h0000_009F_FFFF_F000); // below the base
    queue_request(bcpa_pkg::CMD_FREE, 8191, '1);                   // far beyond the bitmap
    queue_request(bcpa_pkg::CMD_FREE, 1, 64'h0000_00A0_0000_5000); // page 5
    queue_request(bcpa_pkg::CMD_FREE, 1, 64'h0000_00A0_0000_5000); // page 5 again
    queue_request(bcpa_pkg::CMD_ALLOC, 1, '0);                     // takes page 5 back
    settle();

    // A limit beyond the bitmap acts as the full bitmap. The base sits just
    // under the top of the address space so that high grants wrap round.
    set_pages(8191);
    write_reg(bcpa_pkg::CFG_FRAME_BASE, 64'hFFFF_FFFF_FFF0_0000);
    queue_request(bcpa_pkg::CMD_ALLOC, 4096, '0);                  // not below the limit
    queue_request(bcpa_pkg::CMD_ALLOC, 4030, '0);                  // pages 64 to 4093
    queue_request(bcpa_pkg::CMD_ALLOC, 2, '0);                     // 4094, 4095; wraps
    queue_request(bcpa_pkg::CMD_ALLOC, 1, '0);                     // bitmap full
    settle();

    // Pages above the limit but inside the bitmap are still cleared, while
    // the part of the run past the bitmap is dropped.
    set_pages(100);
    queue_request(bcpa_pkg::CMD_FREE, 30, 64'h0000_0000_00EF_0000); // pages 4080 to 4109
    settle();

    set_pages(4096);
    write_reg(bcpa_pkg::CFG_FRAME_BASE, '0);
    queue_request(bcpa_pkg::CMD_ALLOC, 16, '0);                    // only 4080 up are free
    queue_request(bcpa_pkg::CMD_FREE, 4096, '0);                   // empties the bitmap
    settle();

    rand_phase(4096, {$urandom, $urandom}, 40);
    rand_phase(100, {$urandom, $urandom}, 250);
    rand_phase(1, {$urandom, $urandom}, 40);
    rand_phase(64, '1, 250);
    rand_phase(0, {$urandom, $urandom}, 40);
    rand_phase(257, {$urandom, $urandom}, 250);
    rand_phase(8191, '0, 40);
    rand_phase(2, {$urandom, $urandom}, 60);
    rand_phase(128, {$urandom, $urandom}, 250);
    rand_phase(4095, {$urandom, $urandom}, 40);
    rand_phase(200, {$urandom, $urandom}, 250);
    rand_phase(96, {$urandom, $urandom}, 330);

    repeat (16) @(posedge clk);
    if (mismatches == 0 && expected_grants.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
